[src/aabb_pkg.sv]
// aabb_pkg: types and constants shared by the box transform pipeline
// no dependencies; imported by every module of the block

package aabb_pkg;

  // number of configuration registers and their indexes
  localparam int unsigned NUM_REGS = 6;

  typedef enum logic [2:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_reg_e;

  // reset values give the identity matrix
  localparam logic [63:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

  // saturation limits in Q16.16
  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // matrix: three rows of four Q16.16 elements, column 3 is translation
  typedef logic [3:0][31:0] mrow_t;
  typedef mrow_t [2:0] mat_t;

  // one box: minimum and maximum corner, index 0 = x
  typedef struct packed {
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

  // exact Q32.32 products, [row][col]
  typedef struct packed {
    logic [2:0][2:0][63:0] plo;
    logic [2:0][2:0][63:0] phi;
  } prod_set_t;

  // truncated Q32.16 terms after min/max selection, [row][col]
  typedef struct packed {
    logic [2:0][2:0][47:0] tmin;
    logic [2:0][2:0][47:0] tmax;
  } term_set_t;

  // row sums before saturation
  typedef struct packed {
    logic [2:0][49:0] smin;
    logic [2:0][49:0] smax;
  } sum_set_t;

endpackage

[src/aabb_in_if.sv]
// aabb_in_if: input channel carrying one box per item
// no dependencies

interface aabb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_min_x;
  logic signed [31:0] in_min_y;
  logic signed [31:0] in_min_z;
  logic signed [31:0] in_max_x;
  logic signed [31:0] in_max_y;
  logic signed [31:0] in_max_z;

  modport source (
    output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
    input  ready
  );
  modport sink (
    input  valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
    output ready
  );
endinterface

[src/aabb_out_if.sv]
// aabb_out_if: result channel carrying one transformed box per item
// no dependencies

interface aabb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_min_x;
  logic signed [31:0] out_min_y;
  logic signed [31:0] out_min_z;
  logic signed [31:0] out_max_x;
  logic signed [31:0] out_max_y;
  logic signed [31:0] out_max_z;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    input  ready
  );
  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    output ready
  );
endinterface

[src/aabb_affine_transform.sv]
// aabb_affine_transform: top level, box through a configured 3x4 affine matrix
// depends on aabb_pkg, aabb_in_if, aabb_out_if, aabb_cfg_regs and the stage modules
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    in_min_{x,y,z}, in_max_{x,y,z}  Q16.16
//   out_ch    out  valid/ready    out_min_{x,y,z}, out_max_{x,y,z} Q16.16
//   cfg_*     in   cfg_we         cfg_index (3 bits), cfg_data (64 bits)
//
// one item per cycle sustained while out_ch.ready is high; registered stages in order:
// multiply, truncate and order, row sum, saturate into the output register
// reset clears all stage valid bits and loads the identity matrix
// each stage holds its item while the next stage is full and stalled;
// in_ch.ready follows the chain of stage ready signals back from out_ch.ready

module aabb_affine_transform import aabb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  aabb_in_if.sink       in_ch,
  aabb_out_if.source    out_ch
);

  mat_t      mat;
  box_t      in_box;
  prod_set_t prod;
  term_set_t term;
  sum_set_t  sum;
  logic      mul_valid;
  logic      mul_ready;
  logic      sel_valid;
  logic      sel_ready;
  logic      sum_valid;
  logic      sum_ready;

  logic             out_v_r;
  logic [2:0][31:0] lo_r;
  logic [2:0][31:0] hi_r;
  logic [2:0][31:0] lo_nxt;
  logic [2:0][31:0] hi_nxt;

  // matrix registers
  aabb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  // gather the input item
  assign in_box.lo[0] = in_ch.in_min_x;
  assign in_box.lo[1] = in_ch.in_min_y;
  assign in_box.lo[2] = in_ch.in_min_z;
  assign in_box.hi[0] = in_ch.in_max_x;
  assign in_box.hi[1] = in_ch.in_max_y;
  assign in_box.hi[2] = in_ch.in_max_z;

  aabb_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (mat),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_box    (in_box),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prod  (prod)
  );

  aabb_sel_stage u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prod   (prod),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_term  (term)
  );

  aabb_sum_stage u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (mat),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_term   (term),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum)
  );

  // saturate to 32 bits: in range when bits 49:31 all match the sign
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (&sum.smin[r][49:31] || !(|sum.smin[r][49:31])) begin
        lo_nxt[r] = sum.smin[r][31:0];
      end else begin
        lo_nxt[r] = sum.smin[r][49] ? SAT_NEG : SAT_POS;
      end
      if (&sum.smax[r][49:31] || !(|sum.smax[r][49:31])) begin
        hi_nxt[r] = sum.smax[r][31:0];
      end else begin
        hi_nxt[r] = sum.smax[r][49] ? SAT_NEG : SAT_POS;
      end
    end
  end

  // output register
  assign sum_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (sum_ready) begin
      out_v_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_min_x = lo_r[0];
  assign out_ch.out_min_y = lo_r[1];
  assign out_ch.out_min_z = lo_r[2];
  assign out_ch.out_max_x = hi_r[0];
  assign out_ch.out_max_y = hi_r[1];
  assign out_ch.out_max_z = hi_r[2];

`ifndef SYNTHESIS
  // input back-pressure only when every stage is full and the output stalls
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (mul_valid && sel_valid && sum_valid && out_v_r && !out_ch.ready))
    else $error("input stalled while the pipeline has room");

  // a new item in the sum stage came from a valid select stage
  a_sum_fed_by_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sum_valid) |-> $past(sel_valid))
    else $error("sum stage became valid without a source item");

  // ordered sums and monotone saturation keep min at or below max
  a_x_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.out_min_x) <= $signed(out_ch.out_max_x)))
    else $error("x minimum above maximum");

  a_yz_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (($signed(out_ch.out_min_y) <= $signed(out_ch.out_max_y))
                   && ($signed(out_ch.out_min_z) <= $signed(out_ch.out_max_z))))
    else $error("y or z minimum above maximum");
`endif

endmodule

[src/aabb_cfg_regs.sv]
// aabb_cfg_regs: six 64-bit matrix registers behind a plain write port
// depends on aabb_pkg

module aabb_cfg_regs import aabb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output mat_t        mat
);

  logic [NUM_REGS-1:0][63:0] regs_r;

  // register writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_ROW0_COLS01] <= RST_ROW0_COLS01;
      regs_r[REG_ROW0_COLS23] <= RST_ROW0_COLS23;
      regs_r[REG_ROW1_COLS01] <= RST_ROW1_COLS01;
      regs_r[REG_ROW1_COLS23] <= RST_ROW1_COLS23;
      regs_r[REG_ROW2_COLS01] <= RST_ROW2_COLS01;
      regs_r[REG_ROW2_COLS23] <= RST_ROW2_COLS23;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0_COLS01: regs_r[REG_ROW0_COLS01] <= cfg_data;
        REG_ROW0_COLS23: regs_r[REG_ROW0_COLS23] <= cfg_data;
        REG_ROW1_COLS01: regs_r[REG_ROW1_COLS01] <= cfg_data;
        REG_ROW1_COLS23: regs_r[REG_ROW1_COLS23] <= cfg_data;
        REG_ROW2_COLS01: regs_r[REG_ROW2_COLS01] <= cfg_data;
        REG_ROW2_COLS23: regs_r[REG_ROW2_COLS23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack registers into matrix elements
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = regs_r[2*r][31:0];
      mat[r][1] = regs_r[2*r][63:32];
      mat[r][2] = regs_r[2*r+1][31:0];
      mat[r][3] = regs_r[2*r+1][63:32];
    end
  end

endmodule

[src/aabb_mul_stage.sv]
// aabb_mul_stage: first pipeline stage, eighteen exact 32x32 products
// depends on aabb_pkg

module aabb_mul_stage import aabb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mat_t      mat,
  input  logic      in_valid,
  output logic      in_ready,
  input  box_t      in_box,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_set_t out_prod
);

  logic      v_r;
  prod_set_t prod_r;
  prod_set_t prod_nxt;

  assign in_ready = !v_r || out_ready;

  // each matrix element times the min and max coordinate of its column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt.plo[r][c] = $signed(mat[r][c]) * $signed(in_box.lo[c]);
        prod_nxt.phi[r][c] = $signed(mat[r][c]) * $signed(in_box.hi[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_prod  = prod_r;

endmodule

[src/aabb_sel_stage.sv]
// aabb_sel_stage: truncate products to Q32.16 and order each min/max pair
// depends on aabb_pkg

module aabb_sel_stage import aabb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_set_t in_prod,
  output logic      out_valid,
  input  logic      out_ready,
  output term_set_t out_term
);

  logic      v_r;
  term_set_t term_r;
  term_set_t term_nxt;
  logic signed [47:0] a;
  logic signed [47:0] b;

  assign in_ready = !v_r || out_ready;

  // arithmetic shift by 16 keeps bits 63:16, floor rounding
  always_comb begin
    a = '0;
    b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a = $signed(in_prod.plo[r][c][63:16]);
        b = $signed(in_prod.phi[r][c][63:16]);
        if (a <= b) begin
          term_nxt.tmin[r][c] = a;
          term_nxt.tmax[r][c] = b;
        end else begin
          term_nxt.tmin[r][c] = b;
          term_nxt.tmax[r][c] = a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      term_r <= term_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_term  = term_r;

endmodule

[src/aabb_sum_stage.sv]
// aabb_sum_stage: translation plus the three selected terms of each row
// depends on aabb_pkg

module aabb_sum_stage import aabb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mat_t      mat,
  input  logic      in_valid,
  output logic      in_ready,
  input  term_set_t in_term,
  output logic      out_valid,
  input  logic      out_ready,
  output sum_set_t  out_sum
);

  logic     v_r;
  sum_set_t sum_r;
  sum_set_t sum_nxt;

  assign in_ready = !v_r || out_ready;

  // exact signed sums, 50 bits cover three 48-bit terms and the 32-bit translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt.smin[r] = 50'($signed(mat[r][3]))
                      + 50'($signed(in_term.tmin[r][0]))
                      + 50'($signed(in_term.tmin[r][1]))
                      + 50'($signed(in_term.tmin[r][2]));
      sum_nxt.smax[r] = 50'($signed(mat[r][3]))
                      + 50'($signed(in_term.tmax[r][0]))
                      + 50'($signed(in_term.tmax[r][1]))
                      + 50'($signed(in_term.tmax[r][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_sum   = sum_r;

endmodule
